### hdl/dpsm_pkg.sv
// ----------------------------------------------------------------------------
// dpsm_pkg
// Shared types, register indexes, reset values and helpers of the display
// power state manager.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsm_pkg;

  localparam int unsigned DEF_IDLE_COUNT_BITS = 24;
  localparam int unsigned TIMEOUT_BITS        = 24;
  localparam int unsigned LEVEL_BITS          = 7;
  localparam int unsigned TEMP_BITS           = 12;
  localparam int unsigned CFG_INDEX_BITS      = 3;
  localparam int unsigned CFG_DATA_BITS       = 24;

  localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 7'd100;

  typedef enum logic [1:0] {
    PS_ACTIVE = 2'd0,
    PS_DIMMED = 2'd1,
    PS_SLEEP  = 2'd2
  } power_state_e;

  typedef enum logic [1:0] {
    EV_TICK     = 2'd0,
    EV_ACTIVITY = 2'd1,
    EV_TEMP     = 2'd2,
    EV_DIAG     = 2'd3
  } event_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DIM_TIMEOUT   = 3'd0,
    REG_SLEEP_TIMEOUT = 3'd1,
    REG_DIM_LEVEL     = 3'd2,
    REG_HOT_SLEEP     = 3'd3,
    REG_THROTTLE_ON   = 3'd4,
    REG_THROTTLE_OFF  = 3'd5,
    REG_THROTTLE_LVL  = 3'd6
  } cfg_index_e;

  localparam logic [TIMEOUT_BITS-1:0]     RST_DIM_TIMEOUT   = 24'd15000;
  localparam logic [TIMEOUT_BITS-1:0]     RST_SLEEP_TIMEOUT = 24'd30000;
  localparam logic [LEVEL_BITS-1:0]       RST_DIM_LEVEL     = 7'd20;
  localparam logic signed [TEMP_BITS-1:0] RST_HOT_SLEEP     = 12'sd1040;
  localparam logic signed [TEMP_BITS-1:0] RST_THROTTLE_ON   = 12'sd880;
  localparam logic signed [TEMP_BITS-1:0] RST_THROTTLE_OFF  = 12'sd800;
  localparam logic [LEVEL_BITS-1:0]       RST_THROTTLE_LVL  = 7'd30;

  typedef struct packed {
    logic [TIMEOUT_BITS-1:0]     dim_delay_ms;
    logic [TIMEOUT_BITS-1:0]     sleep_timeout_ms;
    logic [LEVEL_BITS-1:0]       dim_brightness;
    logic signed [TEMP_BITS-1:0] hot_sleep_temp;
    logic signed [TEMP_BITS-1:0] throttle_on_temp;
    logic signed [TEMP_BITS-1:0] throttle_off_temp;
    logic [LEVEL_BITS-1:0]       throttle_brightness;
  } cfg_t;

  typedef struct packed {
    event_e                      mode;
    logic signed [TEMP_BITS-1:0] temperature;
    logic                        diag_enable;
    logic [LEVEL_BITS-1:0]       current_brightness;
  } request_t;

  typedef struct packed {
    power_state_e          power_state;
    logic                  brightness_write;
    logic [LEVEL_BITS-1:0] brightness_value;
    logic                  display_wake;
    logic                  display_sleep;
    logic                  clock_restore;
    logic                  throttle_active;
    logic                  diag_active;
  } result_t;

  function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
    return (v > FULL_LEVEL) ? FULL_LEVEL : v;
  endfunction

endpackage

`default_nettype wire

### hdl/dpsm_cfg.sv
// ----------------------------------------------------------------------------
// dpsm_cfg
// Configuration register file: timeouts, brightness levels and thermal limits.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsm_cfg (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_we_i,
  input  wire [dpsm_pkg::CFG_INDEX_BITS-1:0]       cfg_index_i,
  input  wire [dpsm_pkg::CFG_DATA_BITS-1:0]        cfg_wdata_i,
  output dpsm_pkg::cfg_t                           cfg_o
);
  import dpsm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DIM_TIMEOUT:   cfg_d.dim_delay_ms        = cfg_wdata_i[TIMEOUT_BITS-1:0];
        REG_SLEEP_TIMEOUT: cfg_d.sleep_timeout_ms    = cfg_wdata_i[TIMEOUT_BITS-1:0];
        REG_DIM_LEVEL:     cfg_d.dim_brightness      = cfg_wdata_i[LEVEL_BITS-1:0];
        REG_HOT_SLEEP:     cfg_d.hot_sleep_temp      = $signed(cfg_wdata_i[TEMP_BITS-1:0]);
        REG_THROTTLE_ON:   cfg_d.throttle_on_temp    = $signed(cfg_wdata_i[TEMP_BITS-1:0]);
        REG_THROTTLE_OFF:  cfg_d.throttle_off_temp   = $signed(cfg_wdata_i[TEMP_BITS-1:0]);
        REG_THROTTLE_LVL:  cfg_d.throttle_brightness = cfg_wdata_i[LEVEL_BITS-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_delay_ms        <= RST_DIM_TIMEOUT;
      cfg_q.sleep_timeout_ms    <= RST_SLEEP_TIMEOUT;
      cfg_q.dim_brightness      <= RST_DIM_LEVEL;
      cfg_q.hot_sleep_temp      <= RST_HOT_SLEEP;
      cfg_q.throttle_on_temp    <= RST_THROTTLE_ON;
      cfg_q.throttle_off_temp   <= RST_THROTTLE_OFF;
      cfg_q.throttle_brightness <= RST_THROTTLE_LVL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/dpsm_core.sv
// ----------------------------------------------------------------------------
// dpsm_core
// Power state machine: idle counter, saved level, throttle and diagnostics
// flags, and the display commands of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsm_core #(
  parameter int unsigned IDLE_COUNT_BITS = dpsm_pkg::DEF_IDLE_COUNT_BITS
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      step_i,
  input  wire dpsm_pkg::request_t  req_i,
  input  wire dpsm_pkg::cfg_t      cfg_i,
  output dpsm_pkg::result_t        res_o
);
  import dpsm_pkg::*;

  localparam int unsigned CMP_BITS =
    (IDLE_COUNT_BITS > TIMEOUT_BITS) ? IDLE_COUNT_BITS : TIMEOUT_BITS;

  power_state_e               power_q, power_d;
  logic [IDLE_COUNT_BITS-1:0] idle_q, idle_d, idle_inc;
  logic [LEVEL_BITS-1:0]      saved_q, saved_d;
  logic                       throttle_q, throttle_d;
  logic                       diag_q, diag_d;

  logic [LEVEL_BITS-1:0] cur_level;
  logic [CMP_BITS-1:0]   idle_cmp;
  logic                  hit_dim, hit_sleep;
  logic                  go_active, go_dimmed, go_sleep;
  logic                  thr_set, thr_clr, idle_clr, idle_adv;

  assign cur_level = clamp_level(req_i.current_brightness);
  assign idle_inc  = (idle_q == {IDLE_COUNT_BITS{1'b1}}) ? idle_q
                                                         : idle_q + IDLE_COUNT_BITS'(1);
  assign idle_cmp  = CMP_BITS'(idle_inc);
  assign hit_sleep = idle_cmp >= CMP_BITS'(cfg_i.sleep_timeout_ms);
  assign hit_dim   = idle_cmp >= CMP_BITS'(cfg_i.dim_delay_ms);

  // decode the request into transitions
  always_comb begin
    go_active = 1'b0;
    go_dimmed = 1'b0;
    go_sleep  = 1'b0;
    thr_set   = 1'b0;
    thr_clr   = 1'b0;
    idle_clr  = 1'b0;
    idle_adv  = 1'b0;
    unique case (req_i.mode)
      EV_TICK: begin
        if (diag_q) begin
          idle_clr = 1'b1;
        end else begin
          idle_adv = 1'b1;
          if (power_q == PS_ACTIVE) begin
            go_sleep  = hit_sleep;
            go_dimmed = !hit_sleep && hit_dim;
          end else if (power_q == PS_DIMMED) begin
            go_sleep = hit_sleep;
          end
        end
      end
      EV_ACTIVITY: begin
        idle_clr  = 1'b1;
        go_active = (power_q != PS_ACTIVE);
      end
      EV_TEMP: begin
        priority if (req_i.temperature > cfg_i.hot_sleep_temp) begin
          go_sleep = (power_q != PS_SLEEP);
        end else if (req_i.temperature > cfg_i.throttle_on_temp && !throttle_q) begin
          thr_set = 1'b1;
        end else if (req_i.temperature < cfg_i.throttle_off_temp && throttle_q) begin
          thr_clr = 1'b1;
        end else begin
          thr_clr = 1'b0;
        end
      end
      EV_DIAG: begin
        idle_clr = 1'b1;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    power_d    = power_q;
    idle_d     = idle_q;
    saved_d    = saved_q;
    throttle_d = throttle_q;
    diag_d     = diag_q;
    if (step_i) begin
      if (idle_clr) idle_d = '0;
      if (idle_adv) idle_d = idle_inc;
      if (go_active) power_d = PS_ACTIVE;
      if (go_dimmed) begin
        power_d = PS_DIMMED;
        saved_d = cur_level;
      end
      if (go_sleep) power_d = PS_SLEEP;
      if (thr_set) throttle_d = 1'b1;
      if (thr_clr) throttle_d = 1'b0;
      if (req_i.mode == EV_DIAG) diag_d = req_i.diag_enable;
    end
  end

  // display commands
  always_comb begin
    res_o                  = '0;
    res_o.power_state      = power_d;
    res_o.throttle_active  = throttle_d;
    res_o.diag_active      = diag_d;
    res_o.display_sleep    = go_sleep;
    priority if (go_active) begin
      res_o.clock_restore    = 1'b1;
      res_o.display_wake     = 1'b1;
      res_o.brightness_write = 1'b1;
      res_o.brightness_value = saved_q;
    end else if (go_dimmed) begin
      res_o.brightness_write = 1'b1;
      res_o.brightness_value = clamp_level(cfg_i.dim_brightness);
    end else if (thr_set) begin
      res_o.brightness_write = 1'b1;
      res_o.brightness_value = clamp_level(cfg_i.throttle_brightness);
    end else if (thr_clr) begin
      res_o.brightness_write = 1'b1;
      res_o.brightness_value = saved_q;
    end else if (req_i.mode == EV_DIAG) begin
      res_o.brightness_write = 1'b1;
      if (req_i.diag_enable) begin
        res_o.clock_restore    = 1'b1;
        res_o.display_wake     = 1'b1;
        res_o.brightness_value = FULL_LEVEL;
      end else begin
        res_o.brightness_value = saved_q;
      end
    end else begin
      res_o.brightness_write = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q    <= PS_ACTIVE;
      idle_q     <= '0;
      saved_q    <= FULL_LEVEL;
      throttle_q <= 1'b0;
      diag_q     <= 1'b0;
    end else begin
      power_q    <= power_d;
      idle_q     <= idle_d;
      saved_q    <= saved_d;
      throttle_q <= throttle_d;
      diag_q     <= diag_d;
    end
  end

  a_diag_tick_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && diag_q && req_i.mode == EV_TICK |=> idle_q == '0 && $stable(power_q))
    else $error("diagnostics tick changed idle count or power state");

  a_activity_wakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.mode == EV_ACTIVITY |=> power_q == PS_ACTIVE && idle_q == '0)
    else $error("activity did not wake the display");

  a_diag_follows_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.mode == EV_DIAG |=> diag_q == $past(req_i.diag_enable))
    else $error("diagnostics flag does not follow the switch");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(power_q) && $stable(idle_q) && $stable(saved_q))
    else $error("state changed without a request");

endmodule

`default_nettype wire

### hdl/display_power_state_manager_core.sv
// ----------------------------------------------------------------------------
// display_power_state_manager_core
// Display power manager: active, dimmed and sleep states driven by tick,
// activity, temperature and diagnostics events.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i / in_stall_o with the event fields; every
//   request gives exactly one result on out_valid_o / out_stall_i carrying
//   the power state after the event and the display command flags.
//   A request is taken into an input register, processed by the state logic
//   and its result lands in the result register, which drives out_valid_o.
//   One request per cycle is sustained while the receiver does not stall; the
//   only loop is the state update in the core.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; in_stall_o rises only when both
//   are full.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i,
//   one register per cycle, while no request is in flight.
//   Reset: state active, idle count zero, saved level 100, throttle and
//   diagnostics off, registers at their default values, pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none

module display_power_state_manager_core #(
  parameter int unsigned IDLE_COUNT_BITS = dpsm_pkg::DEF_IDLE_COUNT_BITS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [1:0]                           mode_i,
  input  wire  signed [dpsm_pkg::TEMP_BITS-1:0] temperature_i,
  input  wire                                  diag_enable_i,
  input  wire  [dpsm_pkg::LEVEL_BITS-1:0]      current_brightness_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [1:0]                           power_state_o,
  output logic                                 brightness_write_o,
  output logic [dpsm_pkg::LEVEL_BITS-1:0]      brightness_value_o,
  output logic                                 display_wake_o,
  output logic                                 display_sleep_o,
  output logic                                 clock_restore_o,
  output logic                                 throttle_active_o,
  output logic                                 diag_active_o,
  input  wire                                  cfg_we_i,
  input  wire  [dpsm_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire  [dpsm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);
  import dpsm_pkg::*;

  cfg_t     cfg;
  request_t req_q;
  result_t  res, res_q;
  logic     in_valid_q, in_valid_d;
  logic     out_valid_q, out_valid_d;
  logic     accept, advance, fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept)    in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.mode               <= event_e'(mode_i);
      req_q.temperature        <= temperature_i;
      req_q.diag_enable        <= diag_enable_i;
      req_q.current_brightness <= current_brightness_i;
    end
    if (fire) res_q <= res;
  end

  dpsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dpsm_core #(
    .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o        = out_valid_q;
  assign power_state_o      = res_q.power_state;
  assign brightness_write_o = res_q.brightness_write;
  assign brightness_value_o = res_q.brightness_value;
  assign display_wake_o     = res_q.display_wake;
  assign display_sleep_o    = res_q.display_sleep;
  assign clock_restore_o    = res_q.clock_restore;
  assign throttle_active_o  = res_q.throttle_active;
  assign diag_active_o      = res_q.diag_active;

endmodule

`default_nettype wire

### bench/tb_display_power_state_manager_core.sv
// ----------------------------------------------------------------------------
// tb_display_power_state_manager_core
// Self-checking bench for the display power state manager. A scoreboard class
// keeps its own copy of the power state, idle count, saved level, throttle and
// diagnostics flags and predicts the command flags for every accepted request.
// Directed requests cover the corner cases. Random traffic then runs under
// several register settings, the extremes among them, with random idling on
// both channels and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_display_power_state_manager_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dpsm_pkg::*;

  localparam int unsigned IDLE_BITS    = DEF_IDLE_COUNT_BITS;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PHASE_ITEMS  = 150;

  class power_state_board;
    cfg_t                  settings;
    power_state_e          state;
    logic [IDLE_BITS-1:0]  idle_ms;
    logic [LEVEL_BITS-1:0] saved_level;
    logic                  throttled;
    logic                  diag_on;
    result_t               outcome;
    result_t               due_results[$];
    int unsigned           failures;
    int unsigned           checked;
    int unsigned           dim_entries;
    int unsigned           sleep_entries;
    int unsigned           throttle_onsets;
    int unsigned           diag_enables;

    function new();
      settings = '{RST_DIM_TIMEOUT, RST_SLEEP_TIMEOUT, RST_DIM_LEVEL, RST_HOT_SLEEP,
                   RST_THROTTLE_ON, RST_THROTTLE_OFF, RST_THROTTLE_LVL};
      state       = PS_ACTIVE;
      idle_ms     = '0;
      saved_level = FULL_LEVEL;
      throttled   = 1'b0;
      diag_on     = 1'b0;
    endfunction

    function logic [LEVEL_BITS-1:0] cap(logic [LEVEL_BITS-1:0] v);
      return (v > FULL_LEVEL) ? FULL_LEVEL : v;
    endfunction

    function void write_reg(cfg_index_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_DIM_TIMEOUT:   settings.dim_delay_ms        = data[TIMEOUT_BITS-1:0];
        REG_SLEEP_TIMEOUT: settings.sleep_timeout_ms    = data[TIMEOUT_BITS-1:0];
        REG_DIM_LEVEL:     settings.dim_brightness      = data[LEVEL_BITS-1:0];
        REG_HOT_SLEEP:     settings.hot_sleep_temp      = data[TEMP_BITS-1:0];
        REG_THROTTLE_ON:   settings.throttle_on_temp    = data[TEMP_BITS-1:0];
        REG_THROTTLE_OFF:  settings.throttle_off_temp   = data[TEMP_BITS-1:0];
        REG_THROTTLE_LVL:  settings.throttle_brightness = data[LEVEL_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void write_level(logic [LEVEL_BITS-1:0] v);
      outcome.brightness_write = 1'b1;
      outcome.brightness_value = v;
    endfunction

    function void move_to(power_state_e next, logic [LEVEL_BITS-1:0] cur);
      if (next == state) return;
      case (next)
        PS_ACTIVE: begin
          outcome.clock_restore = 1'b1;
          outcome.display_wake  = 1'b1;
          write_level(saved_level);
        end
        PS_DIMMED: begin
          saved_level = cur;
          write_level(cap(settings.dim_brightness));
          dim_entries++;
        end
        default: begin
          outcome.display_sleep = 1'b1;
          sleep_entries++;
        end
      endcase
      state = next;
    endfunction

    function void note_request(request_t r);
      logic [LEVEL_BITS-1:0]       cur;
      logic signed [TEMP_BITS-1:0] t;
      logic signed [TEMP_BITS-1:0] hot;
      logic signed [TEMP_BITS-1:0] on_lim;
      logic signed [TEMP_BITS-1:0] off_lim;
      outcome = '0;
      cur     = cap(r.current_brightness);
      t       = r.temperature;
      hot     = settings.hot_sleep_temp;
      on_lim  = settings.throttle_on_temp;
      off_lim = settings.throttle_off_temp;
      case (r.mode)
        EV_TICK: begin
          if (diag_on) begin
            idle_ms = '0;
          end else begin
            if (idle_ms != '1) idle_ms++;
            if (state == PS_ACTIVE) begin
              if (idle_ms >= settings.sleep_timeout_ms) move_to(PS_SLEEP, cur);
              else if (idle_ms >= settings.dim_delay_ms) move_to(PS_DIMMED, cur);
            end else if (state == PS_DIMMED) begin
              if (idle_ms >= settings.sleep_timeout_ms) move_to(PS_SLEEP, cur);
            end
          end
        end
        EV_ACTIVITY: begin
          idle_ms = '0;
          move_to(PS_ACTIVE, cur);
        end
        EV_TEMP: begin
          if ($signed(t) > $signed(hot)) begin
            move_to(PS_SLEEP, cur);
          end else if ($signed(t) > $signed(on_lim) && !throttled) begin
            throttled = 1'b1;
            write_level(cap(settings.throttle_brightness));
            throttle_onsets++;
          end else if ($signed(t) < $signed(off_lim) && throttled) begin
            throttled = 1'b0;
            write_level(saved_level);
          end
        end
        default: begin
          diag_on = r.diag_enable;
          if (r.diag_enable) begin
            outcome.clock_restore = 1'b1;
            outcome.display_wake  = 1'b1;
            write_level(FULL_LEVEL);
            diag_enables++;
          end else begin
            write_level(saved_level);
          end
          idle_ms = '0;
        end
      endcase
      outcome.power_state     = state;
      outcome.throttle_active = throttled;
      outcome.diag_active     = diag_on;
      due_results.push_back(outcome);
    endfunction

    function void report(string field, logic [LEVEL_BITS-1:0] want,
                         logic [LEVEL_BITS-1:0] got);
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      failures++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding (power_state %0d)", got.power_state);
        failures++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.power_state !== want.power_state)
        report("power_state", want.power_state, got.power_state);
      if (got.brightness_write !== want.brightness_write)
        report("brightness_write", want.brightness_write, got.brightness_write);
      if (got.brightness_value !== want.brightness_value)
        report("brightness_value", want.brightness_value, got.brightness_value);
      if (got.display_wake !== want.display_wake)
        report("display_wake", want.display_wake, got.display_wake);
      if (got.display_sleep !== want.display_sleep)
        report("display_sleep", want.display_sleep, got.display_sleep);
      if (got.clock_restore !== want.clock_restore)
        report("clock_restore", want.clock_restore, got.clock_restore);
      if (got.throttle_active !== want.throttle_active)
        report("throttle_active", want.throttle_active, got.throttle_active);
      if (got.diag_active !== want.diag_active)
        report("diag_active", want.diag_active, got.diag_active);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [1:0]                  mode_i;
  logic signed [TEMP_BITS-1:0] temperature_i;
  logic                        diag_enable_i;
  logic [LEVEL_BITS-1:0]       current_brightness_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [1:0]                  power_state_o;
  logic                        brightness_write_o;
  logic [LEVEL_BITS-1:0]       brightness_value_o;
  logic                        display_wake_o;
  logic                        display_sleep_o;
  logic                        clock_restore_o;
  logic                        throttle_active_o;
  logic                        diag_active_o;
  logic                        cfg_we_i;
  logic [CFG_INDEX_BITS-1:0]   cfg_index_i;
  logic [CFG_DATA_BITS-1:0]    cfg_wdata_i;

  power_state_board board;
  int unsigned      requests_sent;
  int unsigned      results_taken;
  int unsigned      settings_applied;
  bit               sender_gaps;

  display_power_state_manager_core i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stretch without stalls
  initial begin
    int unsigned hold_left;
    bit          held;
    result_t     got;
    hold_left = 0;
    held      = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{power_state_e'(power_state_o), brightness_write_o, brightness_value_o,
                display_wake_o, display_sleep_o, clock_restore_o, throttle_active_o,
                diag_active_o};
        board.check_result(got);
        results_taken++;
      end
      if (!held && results_taken >= 400) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (results_taken >= 600 && results_taken < 760) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 13);
      end
    end
  end

  task automatic send_request(input request_t r);
    while (sender_gaps && !(requests_sent >= 380 && requests_sent < 520)
           && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    mode_i               <= r.mode;
    temperature_i        <= r.temperature;
    diag_enable_i        <= r.diag_enable;
    current_brightness_i <= r.current_brightness;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(r);
    requests_sent++;
  endtask

  task automatic send_event(input event_e m, input int t, input bit en, input int bright);
    request_t r;
    r.mode               = m;
    r.temperature        = TEMP_BITS'(t);
    r.diag_enable        = en;
    r.current_brightness = LEVEL_BITS'(bright);
    send_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_index_e idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // narrow registers get random upper bits, which the block must drop
  task automatic apply_settings(input cfg_t c);
    put_reg(REG_DIM_TIMEOUT, c.dim_delay_ms);
    put_reg(REG_SLEEP_TIMEOUT, c.sleep_timeout_ms);
    put_reg(REG_DIM_LEVEL, {17'($urandom), c.dim_brightness});
    put_reg(REG_HOT_SLEEP, {12'($urandom), c.hot_sleep_temp});
    put_reg(REG_THROTTLE_ON, {12'($urandom), c.throttle_on_temp});
    put_reg(REG_THROTTLE_OFF, {12'($urandom), c.throttle_off_temp});
    put_reg(REG_THROTTLE_LVL, {17'($urandom), c.throttle_brightness});
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    int   on_lim;
    on_lim                = int'($urandom_range(0, 3000)) - 1500;
    c.dim_delay_ms        = TIMEOUT_BITS'($urandom_range(1, 24));
    c.sleep_timeout_ms    = TIMEOUT_BITS'($urandom_range(1, 40));
    c.dim_brightness      = LEVEL_BITS'($urandom_range(0, 127));
    c.throttle_brightness = LEVEL_BITS'($urandom_range(0, 127));
    c.throttle_on_temp    = TEMP_BITS'(on_lim);
    c.throttle_off_temp   = TEMP_BITS'(on_lim - int'($urandom_range(0, 200)));
    c.hot_sleep_temp      = TEMP_BITS'(on_lim + int'($urandom_range(0, 300)));
    return c;
  endfunction

  function automatic request_t random_request(cfg_t c);
    request_t r;
    int       pick;
    int       t;
    pick = $urandom_range(99);
    if (pick < 55)      r.mode = EV_TICK;
    else if (pick < 67) r.mode = EV_ACTIVITY;
    else if (pick < 91) r.mode = EV_TEMP;
    else                r.mode = EV_DIAG;
    r.diag_enable        = (r.mode == EV_DIAG) ? ($urandom_range(99) < 30) : 1'($urandom);
    r.current_brightness = LEVEL_BITS'($urandom_range(0, 127));
    if ($urandom_range(99) < 30) begin
      t = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      case ($urandom_range(2))
        0:       t = int'(c.hot_sleep_temp);
        1:       t = int'(c.throttle_on_temp);
        default: t = int'(c.throttle_off_temp);
      endcase
      t = t + int'($urandom_range(0, 6)) - 3;
      if (t > 2047)  t = 2047;
      if (t < -2048) t = -2048;
    end
    r.temperature = TEMP_BITS'(t);
    return r;
  endfunction

  initial begin
    cfg_t c;
    board            = new();
    requests_sent    = 0;
    results_taken    = 0;
    settings_applied = 0;
    sender_gaps      = 1'b1;
    rst_ni               <= 1'b0;
    in_valid_i           <= 1'b0;
    mode_i               <= EV_TICK;
    temperature_i        <= '0;
    diag_enable_i        <= 1'b0;
    current_brightness_i <= '0;
    cfg_we_i             <= 1'b0;
    cfg_index_i          <= REG_DIM_TIMEOUT;
    cfg_wdata_i          <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults after reset
    send_event(EV_TICK, 0, 0, 0);
    send_event(EV_TEMP, 2047, 0, 10);
    send_event(EV_TEMP, 2047, 1, 10);
    send_event(EV_ACTIVITY, 0, 0, 127);
    send_event(EV_TEMP, 1040, 0, 0);
    send_event(EV_TEMP, 900, 0, 0);
    send_event(EV_TEMP, 800, 0, 0);
    send_event(EV_TEMP, -2048, 0, 0);
    send_event(EV_DIAG, 0, 1, 127);
    send_event(EV_TICK, 0, 0, 0);
    send_event(EV_DIAG, -1, 0, 0);
    send_event(EV_ACTIVITY, 0, 1, 0);
    drain();

    c.dim_delay_ms        = 24'd2;
    c.sleep_timeout_ms    = 24'd4;
    c.dim_brightness      = 7'd127;
    c.hot_sleep_temp      = 12'sd2047;
    c.throttle_on_temp    = 12'sd0;
    c.throttle_off_temp   = -12'sd10;
    c.throttle_brightness = 7'd127;
    apply_settings(c);
    send_event(EV_TICK, 0, 0, 127);
    send_event(EV_TICK, 0, 0, 127);
    send_event(EV_TEMP, 5, 0, 0);
    send_event(EV_TICK, 0, 0, 0);
    send_event(EV_TICK, 0, 0, 0);
    send_event(EV_TICK, 0, 0, 0);
    send_event(EV_TEMP, -2048, 0, 0);
    send_event(EV_ACTIVITY, 0, 0, 55);
    send_event(EV_TICK, 0, 0, 55);
    send_event(EV_TICK, 0, 0, 55);
    send_event(EV_DIAG, 0, 1, 0);
    send_event(EV_ACTIVITY, 0, 0, 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      c = random_settings();
      if (phase == 1) begin
        c = '{24'd0, '1, 7'd127, 12'sd2047, -12'sd2048, 12'sd2047, 7'd0};
      end else if (phase == 2) begin
        c = '{'1, 24'd0, 7'd0, -12'sd2048, 12'sd2047, -12'sd2048, 7'd127};
      end
      apply_settings(c);
      repeat (PHASE_ITEMS) send_request(random_request(board.settings));
      drain();
    end

    repeat (6) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.failures++;
    end
    $display("Covered %0d requests, %0d results checked, %0d register settings.",
             requests_sent, board.checked, settings_applied);
    $display("Saw %0d dims, %0d sleeps, %0d throttle onsets, %0d diagnostics enables.",
             board.dim_entries, board.sleep_entries, board.throttle_onsets,
             board.diag_enables);
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
